// ===== hdl/npc_pkg.sv =====
`default_nettype none
package npc_pkg;
    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W = 8;
    localparam int DIST_W = 18;
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Search token passed from cell to cell.
    typedef struct packed {
        logic              active;
        logic              last;
        rgb_t              query;
        logic [DIST_W-1:0] best_dist;
        logic [IDX_W-1:0]  best_idx;
    } token_t;

    function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return 16'(d * d);
    endfunction

    function automatic logic [7:0] expand5(input logic [4:0] c);
        return {c, 3'b100};
    endfunction
endpackage
`default_nettype wire

// ===== hdl/npc_cell.sv =====
`default_nettype none
module npc_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire npc_pkg::rgb_t   wr_data,
    input  wire logic [7:0]      cell_idx,
    input  wire npc_pkg::token_t tok_in,
    output npc_pkg::token_t      tok_out
);
    import npc_pkg::*;

    rgb_t              entry_reg;
    token_t            tok_reg;
    logic [DIST_W-1:0] cur_dist;
    logic              take;

    // Palette entry held by this cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= '0;
        else if (wr_en)
            entry_reg <= wr_data;
    end

    // Distance to the query and running minimum; strict less keeps the lowest index.
    always_comb
    begin
        cur_dist = DIST_W'(sq_diff(tok_in.query.red, entry_reg.red))
                 + DIST_W'(sq_diff(tok_in.query.green, entry_reg.green))
                 + DIST_W'(sq_diff(tok_in.query.blue, entry_reg.blue));
        take = (cell_idx == '0) || (cur_dist < tok_in.best_dist);
    end

    // Token handed on to the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
        begin
            tok_reg.active <= tok_in.active;
            tok_reg.last   <= tok_in.last;
            tok_reg.query  <= tok_in.query;
            if (take)
            begin
                tok_reg.best_dist <= cur_dist;
                tok_reg.best_idx  <= cell_idx;
            end
            else
            begin
                tok_reg.best_dist <= tok_in.best_dist;
                tok_reg.best_idx  <= tok_in.best_idx;
            end
        end
    end

    assign tok_out = tok_reg;
endmodule
`default_nettype wire

// ===== hdl/nearest_palette_color_search_core.sv =====
`default_nettype none
// Finds the palette entry nearest to a 15-bit color by squared distance, ties going to
// the lowest index. A row of 256 cells each holds one entry; a query token walks the row
// one cell per cycle, and one query is in flight at a time. The next beat is taken no
// earlier than the cycle after the result is taken. Palette writes are accepted whenever
// no query is in flight or waiting.
module nearest_palette_color_search_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        kind,
    input  wire logic [7:0]  entry_index,
    input  wire logic [7:0]  entry_red,
    input  wire logic [7:0]  entry_green,
    input  wire logic [7:0]  entry_blue,
    input  wire logic [14:0] query_color,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       nearest_index
);
    import npc_pkg::*;

    token_t chain [PALETTE_ENTRIES+1];
    token_t launch_tok;
    logic   busy_reg, busy_next;
    logic   accept;
    rgb_t   wr_data;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;
    assign wr_data  = '{red: entry_red, green: entry_green, blue: entry_blue};

    // Token launched into the first cell.
    always_comb
    begin
        launch_tok.active    = accept && (kind == KIND_QUERY);
        launch_tok.last      = 1'b1;
        launch_tok.query     = '{red: expand5(query_color[4:0]),
                                 green: expand5(query_color[9:5]),
                                 blue: expand5(query_color[14:10])};
        launch_tok.best_dist = '0;
        launch_tok.best_idx  = '0;
    end

    assign chain[0] = launch_tok;

    for (genvar i = 0; i < PALETTE_ENTRIES; i++)
    begin : g_cell
        npc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (accept && (kind == KIND_WRITE) && (entry_index == 8'(i))),
            .wr_data (wr_data),
            .cell_idx(8'(i)),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    // Output holding register; busy covers the walk and the wait for the taker.
    logic       out_valid_reg, out_valid_next;
    logic [7:0] idx_reg;
    logic       done;

    assign done = chain[PALETTE_ENTRIES].active && chain[PALETTE_ENTRIES].last;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        busy_next      = busy_reg;
        if (accept && (kind == KIND_QUERY))
            busy_next = 1'b1;
        if (done)
            out_valid_next = 1'b1;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
            busy_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            busy_reg      <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
            idx_reg <= chain[PALETTE_ENTRIES].best_idx;
    end

    assign out_valid     = out_valid_reg;
    assign nearest_index = idx_reg;

`ifndef SYNTHESIS
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy_reg)
        else $error("result left the row with no query in flight");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !in_ready)
        else $error("input taken while a result waits");
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg && $stable(idx_reg))
        else $error("waiting result changed");
`endif
endmodule
`default_nettype wire

// ===== bench/nearest_palette_color_search_core_test.sv =====
`default_nettype none
module nearest_palette_color_search_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import npc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [7:0]  entry_index;
    logic [7:0]  entry_red;
    logic [7:0]  entry_green;
    logic [7:0]  entry_blue;
    logic [14:0] query_color;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  nearest_index;

    // One row of the directed table; want_idx < 0 means the predictor decides.
    typedef struct {
        logic        kind;
        logic [7:0]  idx;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [14:0] color;
        int          want_idx;
    } directed_row_t;

    rgb_t        palette_copy [PALETTE_ENTRIES];
    logic [7:0]  nearest_queue [$];
    int          error_count;
    bit          stall_enable;
    directed_row_t rows [$];

    nearest_palette_color_search_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .entry_index   (entry_index),
        .entry_red     (entry_red),
        .entry_green   (entry_green),
        .entry_blue    (entry_blue),
        .query_color   (query_color),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .nearest_index (nearest_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Nearest entry by squared distance, lowest index on a tie.
    function automatic logic [7:0] nearest_entry(input logic [14:0] color);
        logic [7:0]  qr;
        logic [7:0]  qg;
        logic [7:0]  qb;
        int          dr;
        int          dg;
        int          db;
        int          sq_dist;
        int          best_dist;
        logic [7:0]  best;
        qr = {color[4:0], 3'b100};
        qg = {color[9:5], 3'b100};
        qb = {color[14:10], 3'b100};
        best = 8'd0;
        best_dist = 0;
        for (int e = 0; e < PALETTE_ENTRIES; e++)
        begin
            dr = int'(qr) - int'(palette_copy[e].red);
            dg = int'(qg) - int'(palette_copy[e].green);
            db = int'(qb) - int'(palette_copy[e].blue);
            sq_dist = dr * dr + dg * dg + db * db;
            if (e == 0 || sq_dist < best_dist)
            begin
                best = 8'(e);
                best_dist = sq_dist;
            end
        end
        return best;
    endfunction

    // Hold one beat until accepted, then update the palette copy or queue the answer.
    task automatic send_beat(input logic k, input logic [7:0] idx, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b,
                             input logic [14:0] color, input int want_idx);
        logic [7:0] predicted;
        if (stall_enable && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        entry_index <= idx;
        entry_red   <= r;
        entry_green <= g;
        entry_blue  <= b;
        query_color <= color;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (k == KIND_WRITE)
        begin
            palette_copy[idx] = '{red: r, green: g, blue: b};
        end
        else
        begin
            predicted = nearest_entry(color);
            if (want_idx >= 0 && predicted != 8'(want_idx))
                $display("%0t: table row expects %0d, predictor gives %0d",
                         $time, want_idx, predicted);
            nearest_queue.push_back(want_idx >= 0 ? 8'(want_idx) : predicted);
        end
    endtask

    // Result side: random stalls and the field check.
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (stall_enable && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (nearest_queue.size() == 0)
                begin
                    $display("%0t: unexpected result, actual %0d", $time, nearest_index);
                    error_count++;
                end
                else
                begin
                    if (nearest_index !== nearest_queue[0])
                    begin
                        $display("%0t: nearest_index expected %0d actual %0d",
                                 $time, nearest_queue[0], nearest_index);
                        error_count++;
                    end
                    void'(nearest_queue.pop_front());
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    // Stimulus: directed table, then random writes and queries.
    initial
    begin
        int n;
        int choice;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        error_count = 0;
        stall_enable = 1'b1;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = KIND_WRITE;
        entry_index = '0;
        entry_red   = '0;
        entry_green = '0;
        entry_blue  = '0;
        query_color = '0;
        for (int e = 0; e < PALETTE_ENTRIES; e++)
            palette_copy[e] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset every entry is black, so every query answers entry 0.
        rows.push_back('{KIND_QUERY, 8'd0, 8'd0, 8'd0, 8'd0, 15'h0000, 0});
        rows.push_back('{KIND_QUERY, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 15'h7FFF, 0});
        // White at the top entry wins for a white query.
        rows.push_back('{KIND_WRITE, 8'd255, 8'hFF, 8'hFF, 8'hFF, 15'h7FFF, -1});
        rows.push_back('{KIND_QUERY, 8'd0, 8'd0, 8'd0, 8'd0, 15'h7FFF, 255});
        rows.push_back('{KIND_QUERY, 8'd0, 8'd0, 8'd0, 8'd0, 15'h0000, 0});
        // An exact match on an expanded color wins; a duplicate at a higher index loses.
        rows.push_back('{KIND_WRITE, 8'd7, 8'd12, 8'd84, 8'd252, 15'h0000, -1});
        rows.push_back('{KIND_WRITE, 8'd9, 8'd12, 8'd84, 8'd252, 15'h0000, -1});
        rows.push_back('{KIND_QUERY, 8'd0, 8'd0, 8'd0, 8'd0, {5'd31, 5'd10, 5'd1}, 7});
        rows.push_back('{KIND_WRITE, 8'd128, 8'hFF, 8'h00, 8'h00, 15'h7FFF, -1});
        rows.push_back('{KIND_WRITE, 8'd64, 8'h00, 8'hFF, 8'h00, 15'h7FFF, -1});
        rows.push_back('{KIND_WRITE, 8'd1, 8'h00, 8'h00, 8'hFF, 15'h7FFF, -1});
        rows.push_back('{KIND_QUERY, 8'hAA, 8'h55, 8'hAA, 8'h55, 15'h001F, -1});
        rows.push_back('{KIND_QUERY, 8'h55, 8'hAA, 8'h55, 8'hAA, 15'h03E0, -1});
        rows.push_back('{KIND_QUERY, 8'd0, 8'd0, 8'd0, 8'd0, 15'h7C00, -1});
        rows.push_back('{KIND_QUERY, 8'd0, 8'd0, 8'd0, 8'd0, 15'h5555, -1});
        rows.push_back('{KIND_QUERY, 8'd0, 8'd0, 8'd0, 8'd0, 15'h2AAA, -1});
        // Overwrite entries back to black; the palette ties again on black.
        rows.push_back('{KIND_WRITE, 8'd255, 8'd0, 8'd0, 8'd0, 15'h7FFF, -1});
        rows.push_back('{KIND_WRITE, 8'd128, 8'd0, 8'd0, 8'd0, 15'h2AAA, -1});
        rows.push_back('{KIND_QUERY, 8'd0, 8'd0, 8'd0, 8'd0, 15'h0000, 0});
        foreach (rows[i])
            send_beat(rows[i].kind, rows[i].idx, rows[i].red, rows[i].green,
                      rows[i].blue, rows[i].color, rows[i].want_idx);

        // Random part: writes fill the palette, queries probe it.
        n = 700;
        for (int i = 0; i < n; i++)
        begin
            if (i > n - 60)
                stall_enable = 1'b0;
            choice = $urandom_range(0, 9);
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
            if (choice < 6)
                send_beat(KIND_WRITE, 8'($urandom), r, g, b, 15'($urandom), -1);
            else if (choice < 9)
                send_beat(KIND_QUERY, 8'($urandom), r, g, b, 15'($urandom), -1);
            else
                send_beat(KIND_QUERY, 8'($urandom), r, g, b,
                          {5'($urandom_range(0, 1) * 31), 5'($urandom),
                           5'($urandom_range(0, 1) * 31)}, -1);
        end
        in_valid <= 1'b0;

        // Drain the remaining results, then allow the search latency.
        n = 0;
        while (nearest_queue.size() != 0 && n < 20000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (300) @(posedge clk);
        if (error_count == 0 && nearest_queue.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
